// ===== hdl/rnrp_pkg.sv =====
// Shared types and constants for the clock nibble port.
package rnrp_pkg;

    localparam int RNRP_NUM_REGS = 16;
    localparam int REG_W         = 12;
    localparam int SNAP_REGS     = 7;

    localparam logic [15:0] PORT_A = 16'hd5b8;
    localparam logic [15:0] PORT_B = 16'hd5b9;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    typedef logic [SNAP_REGS-1:0][REG_W-1:0] t_snap;

endpackage

// ===== hdl/rnrp_in_if.sv =====
// Input channel: one bus access plus a binary time snapshot.
interface rnrp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [15:0] addr;
    logic [7:0] wr_data;
    logic [5:0] now_sec;
    logic [5:0] now_min;
    logic [4:0] now_hour;
    logic [4:0] now_mday;
    logic [3:0] now_month;
    logic [7:0] now_year;
    logic [2:0] now_wday;

    modport source (
        output valid, op, addr, wr_data, now_sec, now_min, now_hour,
               now_mday, now_month, now_year, now_wday,
        input  ready
    );
    modport sink (
        input  valid, op, addr, wr_data, now_sec, now_min, now_hour,
               now_mday, now_month, now_year, now_wday,
        output ready
    );
endinterface

// ===== hdl/rnrp_out_if.sv =====
// Output channel: read data byte of one access.
interface rnrp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] rd_data;

    modport source (output valid, rd_data, input ready);
    modport sink (input valid, rd_data, output ready);
endinterface

// ===== hdl/rnrp_bcd_snap.sv =====
// Converts the binary time snapshot into the seven BCD clock registers.
module rnrp_bcd_snap
    import rnrp_pkg::*;
(
    input  logic [5:0] i_sec,
    input  logic [5:0] i_min,
    input  logic [4:0] i_hour,
    input  logic [4:0] i_mday,
    input  logic [3:0] i_month,
    input  logic [7:0] i_year,
    input  logic [2:0] i_wday,
    output t_snap      o_snap
);

    // divide by ten as (v * 205) >> 11, exact for v below 320
    function automatic logic [REG_W-1:0] to_bcd(input logic [8:0] v);
        logic [16:0] prod;
        logic [4:0]  q;
        logic [8:0]  r;
        prod = v * 17'd205;
        q    = prod[15:11];
        r    = v - 9'(q * 9'd10);
        return {3'b000, q, r[3:0]};
    endfunction

    logic [4:0] month_p1;
    logic [3:0] wday_p2;
    logic [2:0] wday_mod;
    logic [3:0] wday_out;

    always_comb begin
        month_p1 = {1'b0, i_month} + 5'd1;
        wday_p2  = {1'b0, i_wday} + 4'd2;
        wday_mod = (wday_p2 >= 4'd7) ? 3'(wday_p2 - 4'd7) : wday_p2[2:0];
        wday_out = {1'b0, wday_mod} + 4'd1;

        o_snap[0] = to_bcd({3'b000, i_sec});
        o_snap[1] = to_bcd({3'b000, i_min});
        o_snap[2] = to_bcd({4'b0000, i_hour});
        o_snap[3] = to_bcd({4'b0000, i_mday});
        o_snap[4] = to_bcd({4'b0000, month_p1});
        o_snap[5] = to_bcd({1'b0, i_year});
        o_snap[6] = to_bcd({5'b00000, wday_out});
    end

endmodule

// ===== hdl/rnrp_port.sv =====
// Phase machine, clock register file and registered read data.
module rnrp_port
    import rnrp_pkg::*;
#(
    parameter int NUM_REGS = RNRP_NUM_REGS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_snap             i_snap,
    rnrp_in_if.sink           i_in,
    rnrp_out_if.source        o_out
);

    localparam int IDX_W = $clog2(NUM_REGS);

    t_phase                 r_phase, n_phase;
    logic [IDX_W-1:0]       r_sel, n_sel;
    logic [REG_W-1:0]       r_partial, n_partial;
    logic [REG_W-1:0]       r_regs [NUM_REGS];
    logic                   r_out_valid;
    logic [7:0]             r_rd_data, n_rd_data;

    logic                   in_ready;
    logic                   accept;
    logic                   hit;
    logic                   snap_load;
    logic                   reg_we;
    logic [REG_W-1:0]       cur_val;
    logic [8:0]             sel_rem;

    assign in_ready    = !r_out_valid || o_out.ready;
    assign i_in.ready  = in_ready;
    assign accept      = i_in.valid && in_ready;
    assign hit         = (i_in.addr == PORT_A) || (i_in.addr == PORT_B);
    assign o_out.valid = r_out_valid;
    assign o_out.rd_data = r_rd_data;

    // wr_data mod NUM_REGS; quotient stays below 32 for NUM_REGS of 8 or more
    always_comb begin
        sel_rem = {1'b0, i_in.wr_data};
        for (int k = 4; k >= 0; k--) begin
            if (sel_rem >= (9'(NUM_REGS) << k)) begin
                sel_rem = sel_rem - (9'(NUM_REGS) << k);
            end
        end
    end

    // a read sees the fresh snapshot for the clock registers
    always_comb begin
        if ({{(8-IDX_W){1'b0}}, r_sel} < 8'(SNAP_REGS)) begin
            cur_val = i_snap[r_sel[2:0]];
        end else begin
            cur_val = r_regs[r_sel];
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_sel     = r_sel;
        n_partial = r_partial;
        n_rd_data = 8'd0;
        snap_load = 1'b0;
        reg_we    = 1'b0;
        if (accept && hit) begin
            if (i_in.op == OP_READ) begin
                snap_load = 1'b1;
                unique case (r_phase)
                    PH_HIGH: begin
                        n_rd_data = cur_val[11:4];
                        n_phase   = PH_LOW;
                    end
                    PH_LOW: begin
                        n_rd_data = {4'b0000, cur_val[3:0]};
                        n_phase   = PH_IDLE;
                    end
                    default: n_phase = r_phase;
                endcase
            end else begin
                unique case (r_phase)
                    PH_HIGH: begin
                        n_partial = {i_in.wr_data, 4'b0000};
                        n_phase   = PH_LOW;
                    end
                    PH_LOW: begin
                        n_partial = r_partial | {4'b0000, i_in.wr_data};
                        reg_we    = 1'b1;
                        n_phase   = PH_IDLE;
                    end
                    default: begin
                        n_sel   = sel_rem[IDX_W-1:0];
                        n_phase = PH_HIGH;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_sel     <= '0;
            r_partial <= '0;
        end else begin
            r_phase   <= n_phase;
            r_sel     <= n_sel;
            r_partial <= n_partial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (reg_we) begin
            r_regs[r_sel] <= n_partial;
        end else if (snap_load) begin
            for (int i = 0; i < SNAP_REGS; i++) begin
                r_regs[i] <= i_snap[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= n_rd_data;
        end
    end

    a_write_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.op == OP_WRITE) |=> (r_rd_data == 8'd0))
        else $error("write item returned nonzero data");

    a_miss_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !hit) |=> $stable(r_phase))
        else $error("access to other address changed phase");

    a_select_goes_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && hit && i_in.op == OP_WRITE && r_phase == PH_IDLE)
        |=> (r_phase == PH_HIGH && r_sel == $past(sel_rem[IDX_W-1:0])))
        else $error("register select did not arm high phase");

    a_low_read_nibble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && hit && i_in.op == OP_READ && r_phase == PH_LOW)
        |=> (r_rd_data[7:4] == 4'd0 && r_phase == PH_IDLE))
        else $error("low nibble read returned high bits");

    a_free_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> in_ready)
        else $error("input stalled with empty output register");

endmodule

// ===== hdl/rtc_nibble_register_port.sv =====
// Top level of the BCD clock nibble port.
//
//  channel | modport       | payload
//  --------+---------------+---------------------------------------------
//  i_in    | rnrp_in_if    | op, addr, wr_data, now_sec .. now_wday
//  o_out   | rnrp_out_if   | rd_data
//
// One item per cycle while the sink keeps up; each result appears in the cycle
// after its item is taken, held in the output register until the sink takes it.
// Input ready is high whenever the output register is empty or being drained.
// Synchronous active-low reset clears phase, select, partial value and all
// clock registers together; no clearing pass is needed.
module rtc_nibble_register_port
    import rnrp_pkg::*;
#(
    parameter int NUM_REGS = RNRP_NUM_REGS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rnrp_in_if.sink     i_in,
    rnrp_out_if.source  o_out
);

    t_snap snap;

    rnrp_bcd_snap u_bcd (
        .i_sec   (i_in.now_sec),
        .i_min   (i_in.now_min),
        .i_hour  (i_in.now_hour),
        .i_mday  (i_in.now_mday),
        .i_month (i_in.now_month),
        .i_year  (i_in.now_year),
        .i_wday  (i_in.now_wday),
        .o_snap  (snap)
    );

    rnrp_port #(
        .NUM_REGS (NUM_REGS)
    ) u_port (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_snap  (snap),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the BCD clock nibble port.
`timescale 1ns / 1ps

module tb;
    import rnrp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  wr_data;
        logic [5:0]  sec;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [7:0]  year;
        logic [2:0]  wday;
    } t_access;

    // Tracks the port's phase machine and register file, queues the read byte
    // that each bus access must return.
    class rd_data_scoreboard;
        t_phase           phase;
        logic [3:0]       sel_index;
        logic [REG_W-1:0] partial;
        logic [REG_W-1:0] regs [RNRP_NUM_REGS];
        logic [7:0]       expected_rd [$];
        int               errors;

        function new();
            phase     = PH_IDLE;
            sel_index = '0;
            partial   = '0;
            foreach (regs[i]) regs[i] = '0;
            errors    = 0;
        endfunction

        function logic [REG_W-1:0] to_bcd(int unsigned v);
            return REG_W'(((v / 10) << 4) | (v % 10));
        endfunction

        function void record_access(t_access a);
            logic [7:0] rd;
            rd = '0;
            if (a.addr == PORT_A || a.addr == PORT_B) begin
                if (a.op == OP_READ) begin
                    // every port read refreshes the time registers first
                    regs[0] = to_bcd(a.sec);
                    regs[1] = to_bcd(a.minute);
                    regs[2] = to_bcd(a.hour);
                    regs[3] = to_bcd(a.mday);
                    regs[4] = to_bcd(a.month + 1);
                    regs[5] = to_bcd(a.year);
                    regs[6] = to_bcd(((a.wday + 2) % 7) + 1);
                    case (phase)
                        PH_HIGH: begin
                            rd    = regs[sel_index][11:4];
                            phase = PH_LOW;
                        end
                        PH_LOW: begin
                            rd    = {4'h0, regs[sel_index][3:0]};
                            phase = PH_IDLE;
                        end
                        default: ;
                    endcase
                end else begin
                    case (phase)
                        PH_HIGH: begin
                            partial = {a.wr_data, 4'h0};
                            phase   = PH_LOW;
                        end
                        PH_LOW: begin
                            partial         = partial | a.wr_data;
                            regs[sel_index] = partial;
                            phase           = PH_IDLE;
                        end
                        default: begin
                            sel_index = a.wr_data[3:0];
                            phase     = PH_HIGH;
                        end
                    endcase
                end
            end
            expected_rd.push_back(rd);
        endfunction

        function void check_read(logic [7:0] got);
            logic [7:0] want;
            if (expected_rd.size() == 0) begin
                $display("%0t: unexpected rd_data, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_rd.pop_front();
                if (got !== want) begin
                    $display("%0t: rd_data mismatch, expected %h, actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_rd.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rnrp_in_if  in_ch ();
    rnrp_out_if out_ch ();

    rtc_nibble_register_port uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rd_data_scoreboard sb = new();

    bit          quiet = 1'b0;
    int          gap_odds = 0;
    int          port_items = 0;
    int unsigned cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    // Values read here are the ones settled before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.record_access('{in_ch.op, in_ch.addr, in_ch.wr_data, in_ch.now_sec,
                               in_ch.now_min, in_ch.now_hour, in_ch.now_mday,
                               in_ch.now_month, in_ch.now_year, in_ch.now_wday});
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_read(out_ch.rd_data);
    end

    // Result side: stall bursts between open stretches.
    initial begin
        out_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    function automatic logic [15:0] pick_port();
        return $urandom_range(0, 1) ? PORT_A : PORT_B;
    endfunction

    // Snapshot is mostly in range; one in four uses the full field width.
    function automatic t_access make(logic op, logic [15:0] addr, logic [7:0] data);
        t_access a;
        a.op      = op;
        a.addr    = addr;
        a.wr_data = data;
        if ($urandom_range(0, 3) == 0) begin
            a.sec    = 6'($urandom);
            a.minute = 6'($urandom);
            a.hour   = 5'($urandom);
            a.mday   = 5'($urandom);
            a.month  = 4'($urandom);
            a.year   = 8'($urandom);
            a.wday   = 3'($urandom);
        end else begin
            a.sec    = 6'($urandom_range(0, 60));
            a.minute = 6'($urandom_range(0, 59));
            a.hour   = 5'($urandom_range(0, 23));
            a.mday   = 5'($urandom_range(1, 31));
            a.month  = 4'($urandom_range(0, 11));
            a.year   = 8'($urandom_range(0, 199));
            a.wday   = 3'($urandom_range(0, 6));
        end
        return a;
    endfunction

    task automatic send(input t_access a);
        if (!quiet && gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= a.op;
        in_ch.addr      <= a.addr;
        in_ch.wr_data   <= a.wr_data;
        in_ch.now_sec   <= a.sec;
        in_ch.now_min   <= a.minute;
        in_ch.now_hour  <= a.hour;
        in_ch.now_mday  <= a.mday;
        in_ch.now_month <= a.month;
        in_ch.now_year  <= a.year;
        in_ch.now_wday  <= a.wday;
        do @(posedge i_clk); while (!in_ch.ready);
        if (a.addr == PORT_A || a.addr == PORT_B)
            port_items++;
    endtask

    initial begin
        t_access    a;
        int         kind;
        int         next_mode;
        logic [7:0] sel;

        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.op        <= OP_READ;
        in_ch.addr      <= '0;
        in_ch.wr_data   <= '0;
        in_ch.now_sec   <= '0;
        in_ch.now_min   <= '0;
        in_ch.now_hour  <= '0;
        in_ch.now_mday  <= '0;
        in_ch.now_month <= '0;
        in_ch.now_year  <= '0;
        in_ch.now_wday  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: foreign addresses, idle read, snapshot extremes, select
        // wrap, full-scale nibble writes, a read breaking into a write.
        send(make(OP_READ, 16'h0000, 8'h00));
        send(make(OP_WRITE, 16'hffff, 8'hff));
        send(make(OP_READ, PORT_A - 16'd1, 8'h00));
        send(make(OP_WRITE, PORT_B + 16'd1, 8'h0a));
        a = make(OP_READ, PORT_A, 8'h00);
        a.sec = '1; a.minute = '1; a.hour = '1; a.mday = '1;
        a.month = '1; a.year = '1; a.wday = '1;
        send(a);
        send(make(OP_WRITE, PORT_A, 8'h00));
        a = make(OP_READ, PORT_B, 8'h00);
        a.sec = 6'd60;
        send(a);
        send(a);
        send(make(OP_WRITE, PORT_B, 8'hf6));
        a = make(OP_READ, PORT_A, 8'h00);
        a.sec = '0; a.minute = '0; a.hour = '0; a.mday = '0;
        a.month = '0; a.year = '0; a.wday = 3'd6;
        send(a);
        send(a);
        send(make(OP_WRITE, PORT_A, 8'h0f));
        send(make(OP_WRITE, PORT_B, 8'hff));
        send(make(OP_WRITE, PORT_A, 8'hff));
        send(make(OP_WRITE, PORT_A, 8'h0f));
        send(make(OP_READ, PORT_A, 8'h00));
        send(make(OP_READ, PORT_B, 8'h00));
        send(make(OP_WRITE, PORT_A, 8'h07));
        send(make(OP_WRITE, PORT_A, 8'h00));
        send(make(OP_WRITE, PORT_A, 8'h00));
        send(make(OP_WRITE, PORT_B, 8'h35));
        send(make(OP_WRITE, PORT_B, 8'hab));
        send(make(OP_READ, PORT_B, 8'h00));

        // Random: mostly well-formed select / nibble sequences.
        next_mode = 0;
        while (port_items < 750) begin
            if (port_items >= next_mode) begin
                gap_odds  = $urandom_range(0, 4);
                next_mode = next_mode + 40;
            end
            if (port_items >= 650)
                quiet = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                sel = 8'($urandom);
                send(make(OP_WRITE, pick_port(), sel));
                if (kind <= 2) begin
                    send(make(OP_READ, pick_port(), 8'($urandom)));
                    send(make(OP_READ, pick_port(), 8'($urandom)));
                end else begin
                    send(make(OP_WRITE, pick_port(), 8'($urandom)));
                    send(make(OP_WRITE, pick_port(), 8'($urandom)));
                    if (kind >= 5) begin
                        // read back what was just stored
                        send(make(OP_WRITE, pick_port(), {4'($urandom), sel[3:0]}));
                        send(make(OP_READ, pick_port(), 8'($urandom)));
                        send(make(OP_READ, pick_port(), 8'($urandom)));
                    end
                end
            end else if (kind == 7) begin
                send(make(1'($urandom), pick_port(), 8'($urandom)));
            end else if (kind == 8) begin
                a = make(1'($urandom), 16'($urandom), 8'($urandom));
                if (a.addr == PORT_A || a.addr == PORT_B)
                    a.addr = a.addr ^ 16'h0100;
                send(a);
            end else begin
                send(make(OP_READ, pick_port(), 8'($urandom)));
            end
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
